// File: rtl/sync_length_crc_deframer_top_macros.svh
// assertion macros shared by the rtl; clk and rst_n come from the using module
`ifndef SYNC_LENGTH_CRC_DEFRAMER_TOP_MACROS_SVH
`define SYNC_LENGTH_CRC_DEFRAMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define SLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLD_ASSERT(lbl, prop, msg)
`define SLD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/sld_pkg.sv
package sld_pkg;

  localparam logic [7:0] SYNC_BYTE       = 8'hA6;
  localparam logic [7:0] RESET_MAX_LEN   = 8'd80;
  localparam logic [7:0] MIN_FRAME_LEN   = 8'd3;
  localparam logic [7:0] LENGTH_POS      = 8'd2;
  localparam logic [15:0] CRC_POLY       = 16'h1021;

  typedef enum logic [1:0] {
    VERDICT_BUSY       = 2'd0,
    VERDICT_GOOD       = 2'd1,
    VERDICT_BAD_LENGTH = 2'd2,
    VERDICT_BAD_CRC    = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'b01,
    PH_FRAME = 2'b10
  } phase_t;

  // one result beat as produced by the frame tracker
  typedef struct packed {
    logic       has;
    logic [7:0] frame_byte;
    logic [7:0] byte_index;
    logic       frame_end;
    verdict_t   verdict;
  } res_t;

endpackage

// File: rtl/sld_rx_if.sv
interface sld_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/sld_frame_if.sv
interface sld_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [7:0] byte_index;
  logic       frame_end;
  logic [1:0] verdict;

  modport source (output valid, output frame_byte, output byte_index,
                  output frame_end, output verdict, input ready);
  modport sink (input valid, input frame_byte, input byte_index,
                input frame_end, input verdict, output ready);
endinterface

// File: rtl/sld_cfg_if.sv
interface sld_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_frame_length;

  modport source (output valid, output max_frame_length, input ready);
  modport sink (input valid, input max_frame_length, output ready);
endinterface

// File: rtl/sync_length_crc_deframer_top.sv
// channel  | dir | beat payload
// in_ch    | in  | rx_byte
// out_ch   | out | frame_byte, byte_index, frame_end, verdict
// cfg_ch   | in  | max_frame_length (always ready)
//
// one byte per cycle sustained while out_ch is ready: an input register feeds the frame tracker and its
// bytewise crc fold, whose result lands in the output register in the same cycle.
// an accepted byte passes the input register, then the output register, on its way to its result beat.
// bytes outside a frame other than the sync byte are consumed with no result beat.
// rst_n is synchronous; it returns to hunting and sets max_frame_length to 80.
// a stalled output holds the input register, and in_ch.ready drops once both are full.
`include "sync_length_crc_deframer_top_macros.svh"

module sync_length_crc_deframer_top (
  input  logic              clk,
  input  logic              rst_n,
  sld_rx_if.sink            in_ch,
  sld_frame_if.source       out_ch,
  sld_cfg_if.sink           cfg_ch
);

  logic          in_valid_r;
  logic [7:0]    in_byte_r;
  logic          out_valid_r, out_valid_nxt;
  sld_pkg::res_t out_r;
  sld_pkg::res_t res;
  logic [7:0]    max_len_r;
  logic          advance;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  sld_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .max_len (max_len_r),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res.has;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_len_r   <= sld_pkg::RESET_MAX_LEN;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        max_len_r <= cfg_ch.max_frame_length;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (advance && res.has) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_r.frame_byte;
  assign out_ch.byte_index = out_r.byte_index;
  assign out_ch.frame_end  = out_r.frame_end;
  assign out_ch.verdict    = out_r.verdict;

  `SLD_ASSERT(a_stall_full, !in_ch.ready |-> in_valid_r && out_valid_r, "input stalled with room to spare")
  `SLD_ASSERT(a_end_verdict, out_valid_r |-> out_r.frame_end == (out_r.verdict != sld_pkg::VERDICT_BUSY), "frame end and verdict disagree")
  `SLD_ASSERT(a_idx0_sync, out_valid_r && out_r.byte_index == 8'd0 |-> out_r.frame_byte == sld_pkg::SYNC_BYTE, "index zero beat is not the sync byte")

endmodule

// File: rtl/sld_crc16.sv
module sld_crc16 (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  // msb-first bytewise fold, eight shift steps
  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ sld_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

// File: rtl/sld_frame_fsm.sv
`include "sync_length_crc_deframer_top_macros.svh"

module sld_frame_fsm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       max_len,
  output sld_pkg::res_t    res
);

  sld_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic [15:0] crc_fold;
  logic [15:0] crc_cur;
  logic [7:0]  len_cur;
  logic [15:0] tail_cur;
  logic        bad_len;
  logic        last;

  sld_crc16 u_crc (
    .crc_i  (crc_r),
    .byte_i (tail_r[15:8]),
    .crc_o  (crc_fold)
  );

  always_comb begin
    crc_cur  = (pos_r >= 8'd2) ? crc_fold : crc_r;
    tail_cur = {tail_r[7:0], rx_byte};
    len_cur  = (pos_r == sld_pkg::LENGTH_POS) ? rx_byte : len_r;
    bad_len  = (pos_r == sld_pkg::LENGTH_POS) &&
               ((rx_byte < sld_pkg::MIN_FRAME_LEN) || (rx_byte > max_len));
    last     = (pos_r >= 8'd2) && ({1'b0, pos_r} + 9'd1 == {1'b0, len_cur});
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    tail_nxt  = tail_r;
    res.has        = 1'b0;
    res.frame_byte = rx_byte;
    res.byte_index = pos_r;
    res.frame_end  = 1'b0;
    res.verdict    = sld_pkg::VERDICT_BUSY;
    case (phase_r)
      sld_pkg::PH_FRAME: begin
        res.has = 1'b1;
        if (bad_len || last) begin
          res.frame_end = 1'b1;
          if (bad_len) begin
            res.verdict = sld_pkg::VERDICT_BAD_LENGTH;
          end else if (crc_cur == tail_cur) begin
            res.verdict = sld_pkg::VERDICT_GOOD;
          end else begin
            res.verdict = sld_pkg::VERDICT_BAD_CRC;
          end
          phase_nxt = sld_pkg::PH_HUNT;
          pos_nxt   = 8'd0;
          len_nxt   = 8'd0;
          crc_nxt   = 16'd0;
          tail_nxt  = 16'd0;
        end else begin
          pos_nxt  = pos_r + 8'd1;
          len_nxt  = len_cur;
          crc_nxt  = crc_cur;
          tail_nxt = tail_cur;
        end
      end
      default: begin
        // hunting; stray phase codes hunt as well
        res.byte_index = 8'd0;
        if (rx_byte == sld_pkg::SYNC_BYTE) begin
          res.has   = 1'b1;
          phase_nxt = sld_pkg::PH_FRAME;
          pos_nxt   = 8'd1;
          len_nxt   = 8'd0;
          crc_nxt   = 16'd0;
          tail_nxt  = {8'h00, rx_byte};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sld_pkg::PH_HUNT;
      pos_r   <= 8'd0;
      len_r   <= 8'd0;
      crc_r   <= 16'd0;
      tail_r  <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      tail_r  <= tail_nxt;
    end
  end

  `SLD_ASSERT(a_end_hunts, step && res.has && res.frame_end |=> phase_r == sld_pkg::PH_HUNT, "frame end did not resume hunting")
  `SLD_ASSERT(a_pos_nonzero, phase_r == sld_pkg::PH_FRAME |-> pos_r != 8'd0, "position zero inside a frame")
  `SLD_ASSERT(a_hunt_sync, phase_r != sld_pkg::PH_FRAME && res.has |-> res.frame_byte == sld_pkg::SYNC_BYTE, "frame started on a non-sync byte")

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0]        frame_byte;
    logic [7:0]        byte_index;
    logic              frame_end;
    sld_pkg::verdict_t verdict;
  } frame_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  sld_rx_if    in_ch ();
  sld_frame_if out_ch ();
  sld_cfg_if   cfg_ch ();

  sync_length_crc_deframer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, mirrors the frame tracker
  logic        in_frame;
  logic [7:0]  next_pos;
  logic [7:0]  len_byte;
  logic [15:0] crc_acc;
  logic [15:0] tail;
  logic [7:0]  max_len_now;

  logic [7:0]  rx_pending[$];
  frame_beat_t beats_due[$];
  frame_beat_t drv_beat;
  frame_beat_t want;

  logic [7:0] gen_limit;
  int frame_bytes_queued = 0;
  int bytes_sent = 0;
  int beats_checked = 0;
  int cfg_writes = 0;
  int errors = 0;
  int verdict_tally[4] = '{0, 0, 0, 0};
  int cycle_no = 0;
  int stuck_cycles = 0;
  logic calm;

  // a recurring stretch with no idling on either side
  assign calm = (cycle_no % 3000) < 600;

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ sld_pkg::CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic void restart_hunt();
    in_frame = 1'b0;
    next_pos = 8'd0;
    len_byte = 8'd0;
    crc_acc  = 16'd0;
    tail     = 16'd0;
  endfunction

  // returns 1 when the byte produces a result beat
  function automatic bit deframe_byte(input logic [7:0] b, output frame_beat_t beat);
    logic [7:0] idx;
    beat = '{b, 8'd0, 1'b0, sld_pkg::VERDICT_BUSY};
    if (!in_frame) begin
      if (b != sld_pkg::SYNC_BYTE) return 1'b0;
      in_frame = 1'b1;
      crc_acc  = 16'd0;
      tail     = {8'd0, b};
      next_pos = 8'd1;
      len_byte = 8'd0;
      return 1'b1;
    end
    idx = next_pos;
    beat.byte_index = idx;
    // the crc trails the newest byte by two places
    if (idx >= sld_pkg::LENGTH_POS) crc_acc = crc16_fold(crc_acc, tail[15:8]);
    tail = {tail[7:0], b};
    if (idx == sld_pkg::LENGTH_POS) begin
      len_byte = b;
      if (b < sld_pkg::MIN_FRAME_LEN || b > max_len_now) begin
        beat.frame_end = 1'b1;
        beat.verdict   = sld_pkg::VERDICT_BAD_LENGTH;
        restart_hunt();
        return 1'b1;
      end
    end
    if (idx >= sld_pkg::LENGTH_POS && {1'b0, idx} + 9'd1 == {1'b0, len_byte}) begin
      beat.frame_end = 1'b1;
      beat.verdict   = (crc_acc == tail) ? sld_pkg::VERDICT_GOOD : sld_pkg::VERDICT_BAD_CRC;
      restart_hunt();
      return 1'b1;
    end
    next_pos = idx + 8'd1;
    return 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        bytes_sent++;
        if (deframe_byte(in_ch.rx_byte, drv_beat)) beats_due.push_back(drv_beat);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
          in_ch.valid   <= 1'b1;
          in_ch.rx_byte <= rx_pending.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (beats_due.size() == 0) begin
          $display("%0t: unexpected beat byte %h idx %0d end %b verdict %0d", $time,
                   out_ch.frame_byte, out_ch.byte_index, out_ch.frame_end, out_ch.verdict);
          errors++;
        end else begin
          want = beats_due.pop_front();
          beats_checked++;
          if (out_ch.frame_byte !== want.frame_byte || out_ch.byte_index !== want.byte_index ||
              out_ch.frame_end !== want.frame_end || out_ch.verdict !== want.verdict) begin
            $display("%0t: mismatch, expected byte %h idx %0d end %b verdict %s", $time,
                     want.frame_byte, want.byte_index, want.frame_end, want.verdict.name());
            $display("%0t:           actual byte %h idx %0d end %b verdict %0d", $time,
                     out_ch.frame_byte, out_ch.byte_index, out_ch.frame_end, out_ch.verdict);
            errors++;
          end
          if (want.frame_end) verdict_tally[want.verdict]++;
        end
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 29);
    end
  end

  // watchdog on cycles with no beat moving anywhere
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STALL_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles, %0d beats still due", $time,
               STALL_LIMIT, beats_due.size());
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_pending.push_back(b);
    frame_bytes_queued++;
  endtask

  task automatic queue_header(input logic [7:0] len_val);
    queue_byte(sld_pkg::SYNC_BYTE);
    queue_byte(8'($urandom_range(0, 255)));
    queue_byte(len_val);
  endtask

  // whole frame; from length five up the trailer is a real crc, optionally spoiled
  task automatic queue_frame(input int len_val, input bit spoil_crc);
    logic [7:0]  body[$];
    logic [15:0] c;
    body.push_back(sld_pkg::SYNC_BYTE);
    body.push_back(8'($urandom_range(0, 255)));
    body.push_back(len_val[7:0]);
    if (len_val >= 5) begin
      while (body.size() < len_val - 2) body.push_back(8'($urandom_range(0, 255)));
      c = 16'd0;
      foreach (body[i]) c = crc16_fold(c, body[i]);
      if (spoil_crc) c = c ^ (16'd1 << $urandom_range(0, 15));
      body.push_back(c[15:8]);
      body.push_back(c[7:0]);
    end else begin
      while (body.size() < len_val) body.push_back(8'($urandom_range(0, 255)));
    end
    foreach (body[i]) queue_byte(body[i]);
  endtask

  task automatic fill_random(input int budget);
    int goal;
    int pick;
    int hi;
    int len_val;
    goal = frame_bytes_queued + budget;
    while (frame_bytes_queued < goal) begin
      pick = $urandom_range(0, 99);
      hi = (gen_limit < 24) ? int'(gen_limit) : 24;
      if (gen_limit < sld_pkg::MIN_FRAME_LEN || pick < 10) begin
        if (gen_limit == 8'd255 || $urandom_range(0, 1))
          queue_header(8'($urandom_range(0, 2)));
        else
          queue_header(8'($urandom_range(gen_limit + 1, 255)));
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 4)) rx_pending.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 23) begin
        // cut short, the following bytes get folded into this frame
        len_val = $urandom_range(3, hi);
        queue_header(8'(len_val));
        repeat ($urandom_range(0, len_val - 3)) queue_byte(8'($urandom_range(0, 255)));
      end else begin
        len_val = ($urandom_range(0, 9) == 0) ? $urandom_range(3, gen_limit)
                                              : $urandom_range(3, hi);
        queue_frame(len_val, $urandom_range(0, 5) == 0);
      end
    end
  endtask

  // checked away from the rising edge so the driver and monitor have settled
  task automatic wait_idle();
    while (rx_pending.size() != 0 || in_ch.valid || beats_due.size() != 0 || out_ch.valid)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [7:0] value);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.max_frame_length <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    max_len_now = value;
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_setting(input logic [7:0] limit, input int budget);
    wait_idle();
    write_max_length(limit);
    gen_limit = limit;
    if (limit >= sld_pkg::MIN_FRAME_LEN) queue_frame(int'(limit), 1'b0);
    fill_random(budget);
  endtask

  initial begin
    rst_n                   = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.rx_byte           = 8'd0;
    out_ch.ready            = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.max_frame_length = 8'd0;
    max_len_now = sld_pkg::RESET_MAX_LEN;
    gen_limit   = sld_pkg::RESET_MAX_LEN;
    restart_hunt();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: noise while hunting, bad lengths on both sides, short and checked frames
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    queue_frame(3, 1'b0);
    queue_header(8'd0);
    queue_header(8'd2);
    queue_header(sld_pkg::RESET_MAX_LEN + 8'd1);
    queue_frame(5, 1'b0);
    queue_frame(5, 1'b1);

    fill_random(200);
    run_setting(8'd3, 150);
    run_setting(8'd255, 200);
    run_setting(8'd2, 100);
    run_setting(8'd0, 100);
    run_setting(8'($urandom_range(3, 255)), 200);
    run_setting(sld_pkg::RESET_MAX_LEN, 150);
    run_setting(8'd255, 150);

    wait_idle();
    if (beats_due.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, beats_due.size());
      errors++;
    end

    $display("sent %0d bytes, checked %0d beats over %0d max length settings",
             bytes_sent, beats_checked, cfg_writes + 1);
    $display("frame ends seen: %0d good, %0d bad length, %0d crc mismatch",
             verdict_tally[sld_pkg::VERDICT_GOOD], verdict_tally[sld_pkg::VERDICT_BAD_LENGTH],
             verdict_tally[sld_pkg::VERDICT_BAD_CRC]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sld_pkg.sv
rtl/sld_rx_if.sv
rtl/sld_frame_if.sv
rtl/sld_cfg_if.sv
rtl/sld_crc16.sv
rtl/sld_frame_fsm.sv
rtl/sync_length_crc_deframer_top.sv
tb/sv/testbench.sv
